[sv/tsq_pkg.sv]
`timescale 1ns / 1ps

package tsq_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 128;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int WORD_W      = 32;

	// Operation codes carried on the input tuser
	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_DEQ   = 2'd1;
	localparam logic [1:0] OP_FRONT = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Status codes carried on the output tuser
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_FETCH      = 4'd0;
	localparam logic [STEP_W-1:0] STEP_TEST_ENQ   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TEST_NONE  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_TEST_OUT   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_MV_TEST    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_MV_RD      = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MV_WR      = 4'd6;
	localparam logic [STEP_W-1:0] STEP_TOP_RD     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT_DATA  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_EMIT_EMPTY = 4'd9;
	localparam logic [STEP_W-1:0] STEP_ENQ_TEST   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_ENQ_PUSH   = 4'd11;
	localparam logic [STEP_W-1:0] STEP_EMIT_ZERO  = 4'd12;
	localparam logic [STEP_W-1:0] STEP_EMIT_FULL  = 4'd13;

	// Jump conditions
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
	localparam logic [COND_W-1:0] C_NO_BEAT   = 4'd2;
	localparam logic [COND_W-1:0] C_OP_ENQ    = 4'd3;
	localparam logic [COND_W-1:0] C_OP_NONE   = 4'd4;
	localparam logic [COND_W-1:0] C_OUT_AVAIL = 4'd5;
	localparam logic [COND_W-1:0] C_IN_EMPTY  = 4'd6;
	localparam logic [COND_W-1:0] C_OUT_EMPTY = 4'd7;
	localparam logic [COND_W-1:0] C_IN_FULL   = 4'd8;
	localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd9;

	// Datapath actions
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] A_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] A_FETCH  = 3'd1;
	localparam logic [ACT_W-1:0] A_IN_WR  = 3'd2;
	localparam logic [ACT_W-1:0] A_IN_RD  = 3'd3;
	localparam logic [ACT_W-1:0] A_OUT_WR = 3'd4;
	localparam logic [ACT_W-1:0] A_OUT_RD = 3'd5;
	localparam logic [ACT_W-1:0] A_EMIT   = 3'd6;

	// Result selection for an emit step
	localparam int RES_W = 2;
	localparam logic [RES_W-1:0] R_DATA  = 2'd0;
	localparam logic [RES_W-1:0] R_EMPTY = 2'd1;
	localparam logic [RES_W-1:0] R_ZERO  = 2'd2;
	localparam logic [RES_W-1:0] R_FULL  = 2'd3;

	// One control word of the program
	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic              fin;
		logic [ACT_W-1:0]  act;
		logic [RES_W-1:0]  res;
	} uword_t;

	// Status flags from the datapath that the jumps test
	typedef struct packed {
		logic in_valid;
		logic op_enq;
		logic op_none;
		logic in_empty;
		logic in_full;
		logic out_empty;
		logic out_busy;
	} flags_t;

	// Program store: a fall-through goes to the next step, or to fetch when fin is set.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{cond: C_ALWAYS, target: STEP_FETCH, fin: 1'b1, act: A_NONE, res: R_ZERO};
		case (step)
			STEP_FETCH:      w = '{C_NO_BEAT,   STEP_FETCH,      1'b0, A_FETCH,  R_ZERO};
			STEP_TEST_ENQ:   w = '{C_OP_ENQ,    STEP_ENQ_TEST,   1'b0, A_NONE,   R_ZERO};
			STEP_TEST_NONE:  w = '{C_OP_NONE,   STEP_EMIT_ZERO,  1'b0, A_NONE,   R_ZERO};
			STEP_TEST_OUT:   w = '{C_OUT_AVAIL, STEP_TOP_RD,     1'b0, A_NONE,   R_ZERO};
			STEP_MV_TEST:    w = '{C_IN_EMPTY,  STEP_TOP_RD,     1'b0, A_NONE,   R_ZERO};
			STEP_MV_RD:      w = '{C_NEVER,     STEP_FETCH,      1'b0, A_IN_RD,  R_ZERO};
			STEP_MV_WR:      w = '{C_ALWAYS,    STEP_MV_TEST,    1'b0, A_OUT_WR, R_ZERO};
			STEP_TOP_RD:     w = '{C_OUT_EMPTY, STEP_EMIT_EMPTY, 1'b0, A_OUT_RD, R_ZERO};
			STEP_EMIT_DATA:  w = '{C_OUT_BUSY,  STEP_EMIT_DATA,  1'b1, A_EMIT,   R_DATA};
			STEP_EMIT_EMPTY: w = '{C_OUT_BUSY,  STEP_EMIT_EMPTY, 1'b1, A_EMIT,   R_EMPTY};
			STEP_ENQ_TEST:   w = '{C_IN_FULL,   STEP_EMIT_FULL,  1'b0, A_NONE,   R_ZERO};
			STEP_ENQ_PUSH:   w = '{C_NEVER,     STEP_FETCH,      1'b0, A_IN_WR,  R_ZERO};
			STEP_EMIT_ZERO:  w = '{C_OUT_BUSY,  STEP_EMIT_ZERO,  1'b1, A_EMIT,   R_ZERO};
			STEP_EMIT_FULL:  w = '{C_OUT_BUSY,  STEP_EMIT_FULL,  1'b1, A_EMIT,   R_FULL};
			default:         w = '{C_ALWAYS,    STEP_FETCH,      1'b1, A_NONE,   R_ZERO};
		endcase
		return w;
	endfunction

endpackage

[sv/two_stack_queue.sv]
`timescale 1ns / 1ps

// First-in first-out queue of 32-bit signed words held in two stacks.
// Input channel: s_tuser carries the operation (enqueue, dequeue, read front),
// s_tdata the word to enqueue. Output channel: one beat per input beat, with
// the status on m_tuser and the dequeued or front word on m_tdata.
// A small microprogram steps a counter through a control store; each step
// drives at most one datapath action and at most one jump test.
// Each routine starts in the fetch step. An enqueue then tests its operation
// and the inbound stack, and pushes its word unless that stack is full;
// dequeue and front read the outbound stack top, or report empty when the
// whole queue is empty. When the outbound stack is empty, each inbound entry
// is first moved across by a test, a read and a write through the single-port
// stacks, and one final test follows. The fetch step that takes the next beat
// follows straight on the emit step that registers the result.
// One item is in work at a time; s_tready is high only in the fetch step, so
// the next item is accepted while the previous result still waits in the
// output register.
// Reset empties both stacks at once (the counts are cleared; the storage
// itself is not). While the receiver stalls the result is held on m_tdata and
// m_tuser, and a program that reaches an emit step waits there meanwhile.
module two_stack_queue
	import tsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] result_value
	output logic [1:0]  m_tuser   // [1:0] status
);

	uword_t uw;
	flags_t flags;

	logic [1:0]        op_q;
	logic [WORD_W-1:0] value_q;
	logic [CNT_W-1:0]  in_cnt_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [ADDR_W-1:0] in_rd_addr;
	logic [ADDR_W-1:0] out_rd_addr;
	logic [WORD_W-1:0] in_rdata_q;
	logic [WORD_W-1:0] out_rdata_q;
	logic [WORD_W-1:0] in_mem  [STACK_DEPTH];
	logic [WORD_W-1:0] out_mem [STACK_DEPTH];
	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_tdata_q;
	logic [1:0]        m_tuser_q;
	logic              out_busy;
	logic              beat_in;
	logic              emit;
	logic [1:0]        res_status;
	logic [WORD_W-1:0] res_word;

	// Program sequencer
	tsq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	// Handshake and step strobes
	assign s_tready = (uw.act == A_FETCH);
	assign beat_in  = s_tvalid && s_tready;
	assign out_busy = m_tvalid_q && !m_tready;
	assign emit     = (uw.act == A_EMIT) && !out_busy;

	// Flags tested by the program
	assign flags.in_valid  = s_tvalid;
	assign flags.op_enq    = (op_q == OP_ENQ);
	assign flags.op_none   = (op_q == OP_NONE);
	assign flags.in_empty  = (in_cnt_q == '0);
	assign flags.in_full   = (in_cnt_q == CNT_W'(STACK_DEPTH));
	assign flags.out_empty = (out_cnt_q == '0);
	assign flags.out_busy  = out_busy;

	// Capture the item on its input beat.
	always_ff @(posedge clk) begin
		if (beat_in) begin
			op_q    <= s_tuser;
			value_q <= s_tdata;
		end
	end

	// Stack pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (uw.act == A_IN_WR) begin
				in_cnt_q <= in_cnt_q + CNT_W'(1);
			end else if (uw.act == A_IN_RD) begin
				in_cnt_q <= in_cnt_q - CNT_W'(1);
			end
			if (uw.act == A_OUT_WR) begin
				out_cnt_q <= out_cnt_q + CNT_W'(1);
			end else if (emit && uw.res == R_DATA && op_q == OP_DEQ) begin
				out_cnt_q <= out_cnt_q - CNT_W'(1);
			end
		end
	end

	// Top-of-stack addresses
	assign in_rd_addr  = in_cnt_q[ADDR_W-1:0] - ADDR_W'(1);
	assign out_rd_addr = out_cnt_q[ADDR_W-1:0] - ADDR_W'(1);

	// Inbound stack storage
	always_ff @(posedge clk) begin
		if (uw.act == A_IN_WR) begin
			in_mem[in_cnt_q[ADDR_W-1:0]] <= value_q;
		end
		if (uw.act == A_IN_RD) begin
			in_rdata_q <= in_mem[in_rd_addr];
		end
	end

	// Outbound stack storage
	always_ff @(posedge clk) begin
		if (uw.act == A_OUT_WR) begin
			out_mem[out_cnt_q[ADDR_W-1:0]] <= in_rdata_q;
		end
		if (uw.act == A_OUT_RD) begin
			out_rdata_q <= out_mem[out_rd_addr];
		end
	end

	// Result selection
	always_comb begin
		case (uw.res)
			R_DATA: begin
				res_status = ST_OK;
				res_word   = out_rdata_q;
			end
			R_EMPTY: begin
				res_status = ST_EMPTY;
				res_word   = '1;
			end
			R_FULL: begin
				res_status = ST_FULL;
				res_word   = '0;
			end
			default: begin
				res_status = ST_OK;
				res_word   = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= res_word;
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[sv/tsq_seq.sv]
`timescale 1ns / 1ps

module tsq_seq
	import tsq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output uword_t uw
);

	logic [STEP_W-1:0] upc_q;
	logic [STEP_W-1:0] upc_next;
	logic              take;

	// Current control word comes straight from the program store.
	assign uw = ucode(upc_q);

	// Evaluate the jump condition of this step.
	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_BEAT:   take = !flags.in_valid;
			C_OP_ENQ:    take = flags.op_enq;
			C_OP_NONE:   take = flags.op_none;
			C_OUT_AVAIL: take = !flags.out_empty;
			C_IN_EMPTY:  take = flags.in_empty;
			C_OUT_EMPTY: take = flags.out_empty;
			C_IN_FULL:   take = flags.in_full;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b1;
		endcase
	end

	// Next step: jump target, fetch at the end of a routine, or the following step.
	always_comb begin
		if (take) begin
			upc_next = uw.target;
		end else if (uw.fin) begin
			upc_next = STEP_FETCH;
		end else begin
			upc_next = upc_q + STEP_W'(1);
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_FETCH;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

[sv/tsq_chk.sv]
`timescale 1ns / 1ps

module tsq_chk
	import tsq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result beat stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Only one item is in work: no input beat in the cycle after one.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again straight after a beat");

	// An empty result always carries all ones.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == 32'hFFFF_FFFF)
		else $error("empty status without all-ones word");

	// A dropped enqueue always carries zero.
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata == 32'd0)
		else $error("full status with non-zero word");

endmodule

bind two_stack_queue tsq_chk u_tsq_chk (.*);
